[hw/rtl/srsw_pkg.sv]
// Package for the selective-repeat sender window.
// Holds the map geometry, the action codes, the controller state type
// and the command and status structs shared by srsw_ctrl and srsw_dpath.
package srsw_pkg;

    localparam int FRAME_COUNT = 1024;
    localparam int WINDOW_MAX  = 16;
    localparam int ROW_W       = 16;
    localparam int ROW_CNT     = FRAME_COUNT / ROW_W;
    localparam int COL_W       = $clog2(ROW_W);
    localparam int ROW_IDX_W   = $clog2(ROW_CNT);
    localparam int SEQ_W       = ROW_IDX_W + COL_W;
    localparam int WIN_W       = 5;
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int IN_DATA_W   = 16;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 16;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);

    localparam logic ACTION_ROUND = 1'b0;
    localparam logic ACTION_RESP  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACK_RD,
        ST_ACK_WR,
        ST_SCAN_RD,
        ST_SCAN_LOAD,
        ST_SCAN_FIND,
        ST_EMIT_LAST,
        ST_EMIT_DONE
    } state_t;

    typedef struct packed {
        logic take;
        logic mem_rd;
        logic ack_wr;
        logic scan_load;
        logic row_inc;
        logic find_step;
        logic emit_last;
        logic emit_done;
    } dp_cmd_t;

    typedef struct packed {
        logic row_empty;
        logic row_end;
        logic pend_valid;
        logic full;
        logic can_load;
    } dp_status_t;

endpackage

[hw/rtl/srsw_ctrl.sv]
// Controller of the selective-repeat sender window.
// Sequences responses and round scans; drives srsw_dpath through dp_cmd_t.
// Depends on srsw_pkg.
module srsw_ctrl
    import srsw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic [IN_USER_W-1:0] s_tuser,
    output logic                 s_tready,
    input  dp_status_t           status,
    output dp_cmd_t              cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == ACTION_RESP) begin
                        state_next = s_tuser[1] ? ST_ACK_RD : ST_IDLE;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_ACK_RD:    state_next = ST_ACK_WR;
            ST_ACK_WR:    state_next = ST_IDLE;
            ST_SCAN_RD:   state_next = ST_SCAN_LOAD;
            ST_SCAN_LOAD: state_next = ST_SCAN_FIND;
            ST_SCAN_FIND: begin
                if (status.row_empty) begin
                    if (status.row_end) begin
                        state_next = status.pend_valid ? ST_EMIT_LAST : ST_EMIT_DONE;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end else if (!status.pend_valid || status.can_load) begin
                    state_next = status.full ? ST_EMIT_LAST : ST_SCAN_FIND;
                end
            end
            ST_EMIT_LAST: begin
                if (status.can_load) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_DONE: begin
                if (status.can_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        cmd           = '0;
        cmd.take      = (state_reg == ST_IDLE) && s_tvalid;
        cmd.mem_rd    = (state_reg == ST_ACK_RD) || (state_reg == ST_SCAN_RD);
        cmd.ack_wr    = (state_reg == ST_ACK_WR);
        cmd.scan_load = (state_reg == ST_SCAN_LOAD);
        cmd.row_inc   = (state_reg == ST_SCAN_FIND) && status.row_empty
                        && !status.row_end;
        cmd.find_step = (state_reg == ST_SCAN_FIND) && !status.row_empty
                        && (!status.pend_valid || status.can_load);
        cmd.emit_last = (state_reg == ST_EMIT_LAST) && status.can_load;
        cmd.emit_done = (state_reg == ST_EMIT_DONE) && status.can_load;
    end

endmodule

[hw/rtl/srsw_dpath.sv]
// Datapath of the selective-repeat sender window.
// Holds the acknowledged map (rows of 16 bits with row valid bits), the
// window register, the scan cursor, the pending frame and the output beat.
// Depends on srsw_pkg.
module srsw_dpath
    import srsw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [WIN_W-1:0]      cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    logic [ROW_W-1:0]     mem [ROW_CNT];
    logic [ROW_CNT-1:0]   row_valid_reg;
    logic [ROW_W-1:0]     rd_raw_reg;
    logic                 rd_valid_reg;
    logic [WIN_W-1:0]     win_reg;
    logic [ROW_IDX_W-1:0] row_reg;
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     left_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 pend_valid_reg;
    logic [SEQ_W-1:0]     pend_seq_reg;
    logic                 out_valid_reg;
    logic [SEQ_W-1:0]     out_seq_reg;
    logic                 out_last_reg;
    logic                 out_done_reg;

    logic [ROW_W-1:0]     rd_data;
    logic [CNT_W-1:0]     win_eff;
    logic [CNT_W-1:0]     cnt_inc;
    logic [COL_W-1:0]     find_col;
    logic [SEQ_W-1:0]     find_seq;
    logic                 can_load;

    function automatic logic [COL_W-1:0] lowest_set(input logic [ROW_W-1:0] v);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = COL_W'(i);
            end
        end
        return idx;
    endfunction

    always_comb begin
        rd_data = rd_valid_reg ? rd_raw_reg : '0;
        if (win_reg == '0) begin
            win_eff = CNT_W'(1);
        end else if (CNT_W'(win_reg) > CNT_W'(WINDOW_MAX)) begin
            win_eff = CNT_W'(WINDOW_MAX);
        end else begin
            win_eff = CNT_W'(win_reg);
        end
        cnt_inc  = cnt_reg + CNT_W'(1);
        find_col = lowest_set(left_reg);
        find_seq = {row_reg, find_col};
        can_load = !out_valid_reg || m_tready;

        status.row_empty  = (left_reg == '0);
        status.row_end    = (row_reg == ROW_IDX_W'(ROW_CNT - 1));
        status.pend_valid = pend_valid_reg;
        status.full       = (cnt_inc == win_eff);
        status.can_load   = can_load;
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            rd_raw_reg <= mem[row_reg];
        end
        if (cmd.ack_wr) begin
            mem[row_reg] <= rd_data | (ROW_W'(1) << col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (cmd.ack_wr) begin
            row_valid_reg[row_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            rd_valid_reg <= row_valid_reg[row_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WINDOW_RESET;
        end else if (cfg_we) begin
            win_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            row_reg <= (s_tuser[0] == ACTION_RESP) ? s_tdata[SEQ_W-1:COL_W] : '0;
            col_reg <= s_tdata[COL_W-1:0];
        end else if (cmd.row_inc) begin
            row_reg <= row_reg + ROW_IDX_W'(1);
        end
        if (cmd.scan_load) begin
            left_reg <= ~rd_data;
        end else if (cmd.find_step) begin
            left_reg <= left_reg & ~(ROW_W'(1) << find_col);
        end
        if (cmd.find_step) begin
            pend_seq_reg <= find_seq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else if (cmd.take) begin
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else if (cmd.find_step) begin
            cnt_reg        <= cnt_inc;
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((cmd.find_step && pend_valid_reg) || cmd.emit_last || cmd.emit_done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.find_step && pend_valid_reg) begin
            out_seq_reg  <= pend_seq_reg;
            out_last_reg <= 1'b0;
            out_done_reg <= 1'b0;
        end else if (cmd.emit_last) begin
            out_seq_reg  <= pend_seq_reg;
            out_last_reg <= 1'b1;
            out_done_reg <= 1'b0;
        end else if (cmd.emit_done) begin
            out_seq_reg  <= '0;
            out_last_reg <= 1'b1;
            out_done_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_seq_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

[hw/rtl/selective_repeat_sender_window_top.sv]
// Channel   Dir  Beat contents
// s_        in   tuser: action, is_ack; tdata: resp_seq
// m_        out  tdata: send_seq; tlast: last; tuser: all_done
// cfg_      in   cfg_wdata: frames per round
//
// An ack beat does a row read, then a row write; a nak needs no map access.
// A round start reads, loads and searches each map row scanned (up to 64 rows), with
// one find step per frame found, through the single read port of the acknowledged map.
// Reset needs no clearing pass: row valid bits make the map read as zero.
// A stalled m_ side holds the scan; s_ is ready only between items.
// Top level of the selective-repeat sender window; depends on srsw_pkg,
// srsw_ctrl and srsw_dpath.
module selective_repeat_sender_window_top
    import srsw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [WIN_W-1:0]      cfg_wdata,      // frames per round
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,        // [9:0] resp_seq, zero pad
    input  logic [IN_USER_W-1:0]  s_tuser,        // [0] action, [1] is_ack
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,        // [9:0] send_seq, zero pad
    output logic                  m_tlast,
    output logic                  m_tuser         // [0] all_done
);

    dp_cmd_t    cmd;
    dp_status_t status;

    srsw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srsw_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

[test/srsw_scoreboard_pkg.sv]
// Scoreboard for the selective-repeat sender window testbench: tracks the
// acknowledged map and window setting, predicts each round's send beats.
// Depends on srsw_pkg for map size, window limits and action codes.
package srsw_scoreboard_pkg;
    import srsw_pkg::*;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic             last;
        logic             done;
    } send_beat_t;

    class window_scoreboard;
        bit               acked[FRAME_COUNT];
        logic [WIN_W-1:0] window;
        send_beat_t       pending_q[$];
        logic [SEQ_W-1:0] round_frames[$];
        int               errors;
        int               rounds;
        int               acks;
        int               naks;
        int               beats;

        function new();
            foreach (acked[i]) acked[i] = 1'b0;
            window = WINDOW_RESET;
            errors = 0;
            rounds = 0;
            acks = 0;
            naks = 0;
            beats = 0;
        endfunction

        function void set_window(logic [WIN_W-1:0] value);
            window = value;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function bit is_acked(int frame);
            return acked[frame];
        endfunction

        function int active_window();
            int w;
            w = int'(window);
            if (w < 1) w = 1;
            if (w > WINDOW_MAX) w = WINDOW_MAX;
            return w;
        endfunction

        function void note_beat(logic action, logic [SEQ_W-1:0] seq, logic ack);
            int w;
            w = active_window();
            if (action == ACTION_RESP) begin
                if (ack) begin
                    acked[seq] = 1'b1;
                    acks++;
                end else begin
                    naks++;
                end
                return;
            end
            rounds++;
            round_frames.delete();
            for (int f = 0; f < FRAME_COUNT && round_frames.size() < w; f++) begin
                if (!acked[f]) round_frames.push_back(SEQ_W'(f));
            end
            if (round_frames.size() == 0) begin
                pending_q.push_back('{seq: '0, last: 1'b1, done: 1'b1});
                return;
            end
            foreach (round_frames[i]) begin
                pending_q.push_back('{seq: round_frames[i],
                                      last: (i == round_frames.size() - 1),
                                      done: 1'b0});
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_beat(logic [OUT_DATA_W-1:0] data, logic last, logic done);
            send_beat_t want;
            beats++;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected beat tdata %0d last %b all_done %b",
                                 data, last, done));
                return;
            end
            want = pending_q.pop_front();
            if (data !== OUT_DATA_W'(want.seq))
                report($sformatf("send_seq: got %0d, want %0d", data, want.seq));
            if (last !== want.last)
                report($sformatf("last on seq %0d: got %b, want %b", want.seq, last, want.last));
            if (done !== want.done)
                report($sformatf("all_done on seq %0d: got %b, want %b",
                                 want.seq, done, want.done));
        endtask
    endclass

endpackage

[test/tb_selective_repeat_sender_window_top.sv]
// Testbench for selective_repeat_sender_window_top: directed and random
// round/response beats checked against a scoreboard prediction.
// Depends on srsw_pkg, srsw_scoreboard_pkg and the block's RTL.
module tb_selective_repeat_sender_window_top;
    timeunit 1ns;
    timeprecision 1ps;
    import srsw_pkg::*;
    import srsw_scoreboard_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int IDLE_GAP    = 8;
    localparam int PHASE_ITEMS = 34;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [WIN_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    window_scoreboard sb = new();
    int items;
    int windows_set;
    int holds;
    int burst_left;
    int quiet_cycles;
    bit idle_on;
    bit hold_req;

    selective_repeat_sender_window_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast, m_tuser);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("tb_selective_repeat_sender_window_top: errors");
            $finish;
        end
    end

    initial begin
        int unsigned cnt;
        int unsigned period;
        int unsigned stall;
        int unsigned mode_left;
        int unsigned mode;
        m_tready = 1'b0;
        mode_left = 0;
        mode = 0;
        cnt = 0;
        period = 2;
        stall = 1;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds++;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 300);
                period = $urandom_range(2, 9);
                stall = $urandom_range(1, period - 1);
                cnt = 0;
            end
            mode_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= (cnt % period) >= stall;
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
            cnt++;
        end
    end

    task automatic pace();
        int unsigned gap;
        if (burst_left > 0) burst_left--;
        if (burst_left != 0 || !idle_on) return;
        burst_left = $urandom_range(1, 10);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    task automatic send_beat(logic action, logic [SEQ_W-1:0] seq, logic ack);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(seq);
        s_tuser  <= {ack, action};
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(action, seq, ack);
        items++;
        pace();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    task automatic write_window(logic [WIN_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_window(value);
        windows_set++;
    endtask

    task automatic run_sequence();
        logic [SEQ_W-1:0] frames[$];
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            send_beat(ACTION_ROUND, SEQ_W'($urandom), 1'($urandom));
            frames = sb.round_frames;
            foreach (frames[i]) begin
                r = $urandom_range(0, 99);
                if (r < 65) send_beat(ACTION_RESP, frames[i], 1'b1);
                else if (r < 90) send_beat(ACTION_RESP, frames[i], 1'b0);
                if (r < 8) send_beat(ACTION_RESP, frames[i], 1'b1);
            end
        end else begin
            case ($urandom_range(0, 3))
                0: send_beat(ACTION_RESP, SEQ_W'($urandom), 1'b1);
                1: send_beat(ACTION_RESP, SEQ_W'($urandom), 1'b0);
                2: send_beat(ACTION_ROUND, SEQ_W'($urandom), 1'($urandom));
                default: send_beat(ACTION_RESP, SEQ_W'($urandom_range(0, 127)), 1'b1);
            endcase
        end
    endtask

    task automatic run_phase(logic [WIN_W-1:0] win, bit bursty, bit squeeze);
        int start;
        wait_idle();
        write_window(win);
        idle_on = bursty;
        burst_left = 0;
        if (squeeze) hold_req = 1'b1;
        start = items;
        while (items - start < PHASE_ITEMS) run_sequence();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        items = 0;
        windows_set = 0;
        holds = 0;
        burst_left = 0;
        quiet_cycles = 0;
        idle_on = 1'b0;
        hold_req = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset window, fresh map
        send_beat(ACTION_ROUND, '0, 1'b0);
        send_beat(ACTION_RESP, '0, 1'b0);
        send_beat(ACTION_ROUND, '1, 1'b1);
        send_beat(ACTION_RESP, SEQ_W'(0), 1'b1);
        send_beat(ACTION_RESP, SEQ_W'(2), 1'b1);
        send_beat(ACTION_RESP, '1, 1'b1);
        send_beat(ACTION_RESP, SEQ_W'(10'h2AA), 1'b1);
        send_beat(ACTION_RESP, SEQ_W'(10'h155), 1'b1);
        send_beat(ACTION_RESP, SEQ_W'(0), 1'b1);
        send_beat(ACTION_ROUND, '0, 1'b0);
        wait_idle();
        write_window(WIN_W'(0));
        send_beat(ACTION_ROUND, '0, 1'b0);
        wait_idle();
        write_window(WIN_W'(WINDOW_MAX));
        send_beat(ACTION_ROUND, '0, 1'b0);
        wait_idle();
        write_window('1);
        send_beat(ACTION_ROUND, '0, 1'b0);
        wait_idle();
        write_window(WIN_W'(WINDOW_MAX + 1));
        send_beat(ACTION_RESP, SEQ_W'(1), 1'b0);
        send_beat(ACTION_ROUND, '0, 1'b0);
        wait_idle();
        write_window(WIN_W'(1));
        send_beat(ACTION_RESP, SEQ_W'(1), 1'b1);
        send_beat(ACTION_ROUND, '0, 1'b0);

        run_phase(WIN_W'(5), 1'b1, 1'b0);
        run_phase(WIN_W'(WINDOW_MAX), 1'b0, 1'b1);
        run_phase(WIN_W'(2), 1'b0, 1'b0);
        run_phase('1, 1'b1, 1'b0);
        run_phase(WIN_W'(0), 1'b1, 1'b0);
        run_phase(WIN_W'(9), 1'b0, 1'b0);
        run_phase(WIN_W'($urandom_range(0, 31)), 1'b1, 1'b0);

        wait_idle();
        write_window(WIN_W'(0));
        idle_on = 1'b0;
        send_beat(ACTION_ROUND, SEQ_W'($urandom), 1'($urandom));

        wait_idle();
        repeat (20) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d send beats never arrived", sb.pending()));
        $display("run covered %0d rounds, %0d acks, %0d naks and %0d send beats",
                 sb.rounds, sb.acks, sb.naks, sb.beats);
        $display("over %0d window settings and %0d long receiver holds",
                 windows_set, holds);
        if (sb.errors == 0)
            $display("tb_selective_repeat_sender_window_top: clean");
        else
            $display("tb_selective_repeat_sender_window_top: errors");
        $finish;
    end

endmodule
